FILE: rtl/multilevel_round_robin_run_queue_unit_assert.svh
// assertion macros used by the checker file
`ifndef MULTILEVEL_ROUND_ROBIN_RUN_QUEUE_UNIT_ASSERT_SVH
`define MULTILEVEL_ROUND_ROBIN_RUN_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define MRQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("run queue check failed");

// next-cycle implication
`define MRQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("run queue check failed");

`endif

FILE: rtl/mrq_pkg.sv
`timescale 1ns / 1ps

package mrq_pkg;

  localparam int USER_QUEUE_BASE = 2;
  localparam int USER_LEVEL_MAX  = 2;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PICK = 2'd2,
    OP_PEEK = 2'd3
  } opcode_e;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_ABSENT  = 2'd1;
  localparam logic [1:0] STAT_REFUSED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_DQ_RD,
    S_DQ_CHK,
    S_WALK,
    S_PICK,
    S_ROT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [3:0] chosen;
    logic [1:0] status;
  } result_t;

endpackage

FILE: rtl/mrq_mem.sv
`timescale 1ns / 1ps

module mrq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mrq_qsel.sv
`timescale 1ns / 1ps

module mrq_qsel #(
  parameter int NUM_QUEUES = 5
) (
  input  logic                          user_task_i,
  input  logic signed [3:0]             user_level_i,
  input  logic [2:0]                    tier_queue_i,
  input  logic [NUM_QUEUES-1:0]         nonempty_i,
  output logic [$clog2(NUM_QUEUES)-1:0] target_o,
  output logic                          found_o,
  output logic [$clog2(NUM_QUEUES)-1:0] first_o
);

  import mrq_pkg::*;

  localparam int QW = $clog2(NUM_QUEUES);

  logic [1:0] lvl;
  logic [4:0] raw;

  always_comb begin
    if (user_level_i[3]) begin
      lvl = 2'd0;
    end else if (user_level_i[2:0] > 3'(USER_LEVEL_MAX)) begin
      lvl = 2'(USER_LEVEL_MAX);
    end else begin
      lvl = user_level_i[1:0];
    end
    if (user_task_i) begin
      raw = 5'(USER_QUEUE_BASE) + {3'b000, lvl};
    end else begin
      raw = {2'b00, tier_queue_i};
    end
    // saturate to the last queue
    if (raw >= 5'(NUM_QUEUES)) begin
      raw = 5'(NUM_QUEUES - 1);
    end
    target_o = QW'(raw);
  end

  always_comb begin
    found_o = |nonempty_i;
    first_o = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (nonempty_i[i]) begin
        first_o = QW'(i);
      end
    end
  end

endmodule

FILE: rtl/multilevel_round_robin_run_queue_unit.sv
`timescale 1ns / 1ps
// Multilevel round-robin run queue: NUM_QUEUES linked FIFO lists of task
// slots, queue 0 served first.
// Request channel: in_valid_i / in_stall_o with opcode_i, task_id_i,
// user_task_i, user_level_i, tier_queue_i. A request is taken when valid is
// high and stall is low; stall stays high while a request is being worked.
// Result channel: out_valid_o / out_stall_i with chosen_task_o, status_o,
// one result per request, held in an output register.
// States from accept to result: enqueue passes S_ENQ, peek and a pick of a
// lone task S_PICK, a pick with rotation S_PICK then S_ROT, and dequeue
// S_DQ_RD, S_DQ_CHK and one S_WALK step per list position walked to find the
// predecessor. Each ends in S_DONE, which loads the output register. The walk does one
// link memory read and one compare per cycle. A new request is taken the
// cycle after the result is loaded, even while that result is still stalled.
// A result that cannot leave the sequencer (output register full and
// stalled) holds the block in its final state until the register drains.
// Reset clears the queued and link flags and all queue heads, tails and
// non-empty flags at once; the block is ready right after reset.
module multilevel_round_robin_run_queue_unit #(
  parameter int NUM_TASKS  = 16,
  parameter int NUM_QUEUES = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [3:0]        task_id_i,
  input  logic              user_task_i,
  input  logic signed [3:0] user_level_i,
  input  logic [2:0]        tier_queue_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        chosen_task_o,
  output logic [1:0]        status_o
);

  import mrq_pkg::*;

  localparam int TW = $clog2(NUM_TASKS);
  localparam int QW = $clog2(NUM_QUEUES);

  state_e state_q, state_d;

  opcode_e       op_q;
  logic [TW-1:0] t_q;
  logic          tok_q;
  logic [QW-1:0] q_q, q_d;
  logic [TW-1:0] cur_q, cur_d;
  logic [TW-1:0] nt_q, nt_d;
  logic [TW-1:0] step_q, step_d;
  result_t       res_q, res_d;
  result_t       out_q;
  logic          out_valid_q;

  logic [NUM_TASKS-1:0]  link_valid_q, link_valid_d;
  logic [NUM_TASKS-1:0]  queued_q, queued_d;
  logic [NUM_QUEUES-1:0] nonempty_q, nonempty_d;
  logic [TW-1:0]         head_q [NUM_QUEUES];
  logic [TW-1:0]         head_d [NUM_QUEUES];
  logic [TW-1:0]         tail_q [NUM_QUEUES];
  logic [TW-1:0]         tail_d [NUM_QUEUES];

  logic          nl_we;
  logic [TW-1:0] nl_waddr, nl_wdata, nl_raddr, nl_rdata;
  logic          tq_we;
  logic [QW-1:0] tq_rdata;

  logic [QW-1:0] target;
  logic          found;
  logic [QW-1:0] first;

  logic in_accept;
  logic out_free;
  logic [TW-1:0] h;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  mrq_qsel #(
    .NUM_QUEUES(NUM_QUEUES)
  ) u_qsel (
    .user_task_i (user_task_i),
    .user_level_i(user_level_i),
    .tier_queue_i(tier_queue_i),
    .nonempty_i  (nonempty_q),
    .target_o    (target),
    .found_o     (found),
    .first_o     (first)
  );

  mrq_mem #(
    .DEPTH(NUM_TASKS),
    .WIDTH(TW)
  ) u_next_link (
    .clk_i  (clk_i),
    .we_i   (nl_we),
    .waddr_i(nl_waddr),
    .wdata_i(nl_wdata),
    .raddr_i(nl_raddr),
    .rdata_o(nl_rdata)
  );

  mrq_mem #(
    .DEPTH(NUM_TASKS),
    .WIDTH(QW)
  ) u_task_queue (
    .clk_i  (clk_i),
    .we_i   (tq_we),
    .waddr_i(t_q),
    .wdata_i(q_q),
    .raddr_i(t_q),
    .rdata_o(tq_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      link_valid_q <= '0;
      queued_q     <= '0;
      nonempty_q   <= '0;
      head_q       <= '{default: '0};
      tail_q       <= '{default: '0};
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      link_valid_q <= link_valid_d;
      queued_q     <= queued_d;
      nonempty_q   <= nonempty_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= opcode_e'(opcode_i);
      t_q   <= TW'(task_id_i);
      tok_q <= int'(task_id_i) < NUM_TASKS;
      q_q   <= target;
    end else begin
      q_q <= q_d;
    end
    cur_q  <= cur_d;
    nt_q   <= nt_d;
    step_q <= step_d;
    res_q  <= res_d;
    if (state_q == S_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    q_d          = q_q;
    cur_d        = cur_q;
    nt_d         = nt_q;
    step_d       = step_q;
    res_d        = res_q;
    link_valid_d = link_valid_q;
    queued_d     = queued_q;
    nonempty_d   = nonempty_q;
    head_d       = head_q;
    tail_d       = tail_q;
    nl_we        = 1'b0;
    nl_waddr     = cur_q;
    nl_wdata     = nt_q;
    nl_raddr     = t_q;
    tq_we        = 1'b0;
    h            = head_q[first];

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (opcode_e'(opcode_i))
            OP_ENQ:  state_d = S_ENQ;
            OP_DEQ:  state_d = S_DQ_RD;
            default: state_d = S_PICK;
          endcase
        end
      end

      S_ENQ: begin
        state_d = S_DONE;
        res_d   = '{chosen: 4'd0, status: STAT_OK};
        if (!tok_q) begin
          res_d.status = STAT_ABSENT;
        end else if (queued_q[t_q]) begin
          res_d.status = STAT_REFUSED;
        end else begin
          tq_we              = 1'b1;
          queued_d[t_q]      = 1'b1;
          link_valid_d[t_q]  = 1'b0;
          if (nonempty_q[q_q]) begin
            nl_we                      = 1'b1;
            nl_waddr                   = tail_q[q_q];
            nl_wdata                   = t_q;
            link_valid_d[tail_q[q_q]]  = 1'b1;
            tail_d[q_q]                = t_q;
          end else begin
            head_d[q_q]     = t_q;
            tail_d[q_q]     = t_q;
            nonempty_d[q_q] = 1'b1;
          end
        end
      end

      S_DQ_RD: begin
        res_d = '{chosen: 4'd0, status: STAT_ABSENT};
        if (!tok_q || !queued_q[t_q]) begin
          state_d = S_DONE;
        end else begin
          state_d = S_DQ_CHK;
        end
      end

      S_DQ_CHK: begin
        q_d  = tq_rdata;
        nt_d = nl_rdata;
        if (!(int'(tq_rdata) < NUM_QUEUES) || !nonempty_q[tq_rdata]) begin
          state_d = S_DONE;
        end else if (head_q[tq_rdata] == t_q) begin
          if (link_valid_q[t_q]) begin
            head_d[tq_rdata] = nl_rdata;
          end else begin
            nonempty_d[tq_rdata] = 1'b0;
            head_d[tq_rdata]     = '0;
            tail_d[tq_rdata]     = '0;
          end
          link_valid_d[t_q] = 1'b0;
          queued_d[t_q]     = 1'b0;
          res_d.status      = STAT_OK;
          state_d           = S_DONE;
        end else begin
          cur_d  = head_q[tq_rdata];
          step_d = '0;
          if (!link_valid_q[head_q[tq_rdata]]) begin
            state_d = S_DONE;
          end else begin
            nl_raddr = head_q[tq_rdata];
            state_d  = S_WALK;
          end
        end
      end

      // one list position per cycle: compare successor, fetch the next
      S_WALK: begin
        if (nl_rdata == t_q) begin
          nl_we               = 1'b1;
          nl_waddr            = cur_q;
          nl_wdata            = nt_q;
          link_valid_d[cur_q] = link_valid_q[t_q];
          link_valid_d[t_q]   = 1'b0;
          queued_d[t_q]       = 1'b0;
          if (tail_q[q_q] == t_q) begin
            tail_d[q_q] = cur_q;
          end
          res_d.status = STAT_OK;
          state_d      = S_DONE;
        end else if (step_q == TW'(NUM_TASKS - 1) || !link_valid_q[nl_rdata]) begin
          state_d = S_DONE;
        end else begin
          cur_d    = nl_rdata;
          step_d   = step_q + 1'b1;
          nl_raddr = nl_rdata;
        end
      end

      S_PICK: begin
        state_d = S_DONE;
        if (!found) begin
          res_d = '{chosen: 4'd0, status: STAT_ABSENT};
        end else begin
          q_d   = first;
          cur_d = h;
          res_d = '{chosen: 4'(h), status: STAT_OK};
          if (op_q == OP_PICK) begin
            if (link_valid_q[h]) begin
              nl_raddr = h;
              state_d  = S_ROT;
            end else begin
              nonempty_d[first] = 1'b0;
              head_d[first]     = '0;
              tail_d[first]     = '0;
              queued_d[h]       = 1'b0;
            end
          end
        end
      end

      // head moves to the tail
      S_ROT: begin
        head_d[q_q]               = nl_rdata;
        nl_we                     = 1'b1;
        nl_waddr                  = tail_q[q_q];
        nl_wdata                  = cur_q;
        link_valid_d[tail_q[q_q]] = 1'b1;
        tail_d[q_q]               = cur_q;
        link_valid_d[cur_q]       = 1'b0;
        state_d                   = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign chosen_task_o = out_q.chosen;
  assign status_o      = out_q.status;

endmodule

FILE: rtl/mrq_checker.sv
`timescale 1ns / 1ps
`include "multilevel_round_robin_run_queue_unit_assert.svh"

module mrq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [1:0]        opcode_i,
  input logic [3:0]        task_id_i,
  input logic              user_task_i,
  input logic signed [3:0] user_level_i,
  input logic [2:0]        tier_queue_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [3:0]        chosen_task_o,
  input logic [1:0]        status_o
);

  import mrq_pkg::*;

  `MRQ_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(chosen_task_o) && $stable(status_o))
  `MRQ_ASSERT_IMPL(a_no_task_on_fail, out_valid_o && (status_o != STAT_OK), chosen_task_o == 4'd0)
  `MRQ_ASSERT_IMPL(a_status_code, out_valid_o, status_o == STAT_OK || status_o == STAT_ABSENT || status_o == STAT_REFUSED)
  `MRQ_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind multilevel_round_robin_run_queue_unit mrq_checker u_mrq_checker (.*);
